// ===== design/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants, result codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int C_VALUE_BITS  = 16;
    localparam int C_TABLE_DEPTH = 32768;
    localparam int C_MAX_ITEMS   = 6;
    localparam int C_ENTRY_W     = 8;
    localparam int C_FIELD_W     = 16;

    localparam logic       REQ_BUILD = 1'b0;
    localparam logic       REQ_QUERY = 1'b1;

    localparam logic [2:0] ST_FACTOR    = 3'd0;
    localparam logic [2:0] ST_BUILT     = 3'd1;
    localparam logic [2:0] ST_ABOVE     = 3'd2;
    localparam logic [2:0] ST_BELOW_TWO = 3'd3;
    localparam logic [2:0] ST_NOT_BUILT = 3'd4;

    typedef struct packed {
        logic       take;
        logic       clr_step;
        logic       sp_init;
        logic       sp_sq;
        logic       p_next;
        logic       rd_p;
        logic       rd_m;
        logic       wr_m;
        logic       set_built;
        logic       rd_v;
        logic       f_sel;
        logic       div_step;
        logic       f_chk;
        logic       emit_fac;
        logic       emit_sts;
        logic [2:0] sts_code;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic m_gt_lim;
        logic entry_nz;
        logic built;
        logic v_lt2;
        logic v_gt_lim;
        logic div_done;
        logic again;
        logic out_free;
        logic fac_last;
    } t_sts;

endpackage

// ===== design/spf_req_if.sv =====
// ----------------------------------------------------------------------------
// spf_req_if
// Request channel: build or factorize transactions.
// ----------------------------------------------------------------------------
interface spf_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] query_value;

    modport source (output valid, output req_type, output query_value, input ready);
    modport sink   (input valid, input req_type, input query_value, output ready);
endinterface

// ===== design/spf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spf_rsp_if
// Result channel: (prime, exponent) items or one status item per transaction.
// ----------------------------------------------------------------------------
interface spf_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] prime;
    logic [3:0]  exponent;
    logic        last;
    logic [2:0]  status;

    modport source (output valid, output prime, output exponent, output last,
                    output status, input ready);
    modport sink   (input valid, input prime, input exponent, input last,
                    input status, output ready);
endinterface

// ===== design/spf_sieve_factorizer.sv =====
// ----------------------------------------------------------------------------
// spf_sieve_factorizer
// Smallest-prime-factor sieve table with a factorizing query port.
// ----------------------------------------------------------------------------
// Build: the table is cleared entry by entry, then each candidate prime and
// each sieve mark is handled in turn, all bound by the single table port.
// Query: checks first, then per factor a table lookup, divisor selection,
// repeated divisions in the serial divider and emitting the item.
// One transaction is processed at a time; the result register frees the input.
// Reset clears control state and the built flag and sets the limit to all ones, not the table.
module spf_sieve_factorizer #(
    parameter int VALUE_BITS  = spf_pkg::C_VALUE_BITS,
    parameter int TABLE_DEPTH = spf_pkg::C_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data,
    spf_req_if.sink      i_req,
    spf_rsp_if.source    o_rsp
);
    import spf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign o_cfg_ready = 1'b1;
    assign i_req.ready = w_ready;

    spf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    spf_dpath #(
        .VALUE_BITS  (VALUE_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_query_value  (i_req.query_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_rsp_prime    (o_rsp.prime),
        .o_rsp_exponent (o_rsp.exponent),
        .o_rsp_last     (o_rsp.last),
        .o_rsp_status   (o_rsp.status)
    );

endmodule

// ===== design/spf_ctrl.sv =====
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer for table clearing, sieving and factorization.
// ----------------------------------------------------------------------------
module spf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_type,
    output logic          o_req_ready,
    input  spf_pkg::t_sts i_sts,
    output spf_pkg::t_cmd o_cmd
);
    import spf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QCHK   = 4'd1;
    localparam logic [3:0] S_SEMIT  = 4'd2;
    localparam logic [3:0] S_CLR    = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_TEST   = 4'd5;
    localparam logic [3:0] S_PCHK   = 4'd6;
    localparam logic [3:0] S_MRD    = 4'd7;
    localparam logic [3:0] S_MWR    = 4'd8;
    localparam logic [3:0] S_FLOOK  = 4'd9;
    localparam logic [3:0] S_FSEL   = 4'd10;
    localparam logic [3:0] S_FDIV   = 4'd11;
    localparam logic [3:0] S_FCHK   = 4'd12;
    localparam logic [3:0] S_FEMIT  = 4'd13;

    logic [3:0] r_state, n_state;
    logic [2:0] r_code,  n_code;

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_FACTOR;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.sts_code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = (i_req_type == REQ_BUILD) ? S_CLR : S_QCHK;
                end
            end
            S_QCHK: begin
                if (!i_sts.built) begin
                    n_code  = ST_NOT_BUILT;
                    n_state = S_SEMIT;
                end else if (i_sts.v_lt2) begin
                    n_code  = ST_BELOW_TWO;
                    n_state = S_SEMIT;
                end else if (i_sts.v_gt_lim) begin
                    n_code  = ST_ABOVE;
                    n_state = S_SEMIT;
                end else begin
                    n_state = S_FLOOK;
                end
            end
            S_SEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sts = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.sp_init = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sp_sq = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_sts.m_gt_lim) begin
                    o_cmd.set_built = 1'b1;
                    n_code  = ST_BUILT;
                    n_state = S_SEMIT;
                end else begin
                    o_cmd.rd_p = 1'b1;
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (i_sts.entry_nz) begin
                    o_cmd.p_next = 1'b1;
                    n_state = S_SQ;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                if (i_sts.m_gt_lim) begin
                    o_cmd.p_next = 1'b1;
                    n_state = S_SQ;
                end else begin
                    o_cmd.rd_m = 1'b1;
                    n_state = S_MWR;
                end
            end
            S_MWR: begin
                o_cmd.wr_m = 1'b1;
                n_state = S_MRD;
            end
            S_FLOOK: begin
                o_cmd.rd_v = 1'b1;
                n_state = S_FSEL;
            end
            S_FSEL: begin
                o_cmd.f_sel = 1'b1;
                n_state = S_FDIV;
            end
            S_FDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                o_cmd.f_chk = 1'b1;
                n_state = i_sts.again ? S_FDIV : S_FEMIT;
            end
            S_FEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fac = 1'b1;
                    n_state = i_sts.fac_last ? S_IDLE : S_FLOOK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/spf_dpath.sv =====
// ----------------------------------------------------------------------------
// spf_dpath
// Sieve table memory, sieve counters, serial divider and result register.
// ----------------------------------------------------------------------------
module spf_dpath #(
    parameter int VALUE_BITS  = spf_pkg::C_VALUE_BITS,
    parameter int TABLE_DEPTH = spf_pkg::C_TABLE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_data,
    input  logic [15:0]   i_query_value,
    input  spf_pkg::t_cmd i_cmd,
    output spf_pkg::t_sts o_sts,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    output logic [15:0]   o_rsp_prime,
    output logic [3:0]    o_rsp_exponent,
    output logic          o_rsp_last,
    output logic [2:0]    o_rsp_status
);
    import spf_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int MW = 2 * VALUE_BITS;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(VALUE_BITS);
    localparam logic [63:0] MASK_C = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [63:0] DCAP_C = 64'(2 * TABLE_DEPTH) - 64'd1;
    localparam logic [63:0] DEPTH_C = 64'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [2:0] LAST_ITEM = 3'(C_MAX_ITEMS - 1);

    logic [C_ENTRY_W-1:0] r_mem [TABLE_DEPTH];

    logic [15:0]          r_limit;
    logic                 r_built;
    logic [VB-1:0]        r_v;
    logic [VB-1:0]        r_p;
    logic [MW-1:0]        r_m;
    logic [IW-1:0]        r_idx;
    logic [C_ENTRY_W-1:0] r_rd_data;
    logic                 r_rd_inr;
    logic [VB-1:0]        r_q;
    logic [VB:0]          r_rem;
    logic [CW-1:0]        r_cnt;
    logic [3:0]           r_e;
    logic                 r_first;
    logic [2:0]           r_n;

    logic [63:0]          w_lim64;
    logic [VB-1:0]        w_lim;
    logic [63:0]          w_vidx;
    logic [63:0]          w_pidx;
    logic [63:0]          w_midx;
    logic [VB+15:0]       w_qext;
    logic [VB+15:0]       w_pext;
    logic [VB:0]          w_rsh;
    logic [VB:0]          w_rsub;
    logic [VB-1:0]        w_entry;
    logic [VB-1:0]        w_psel;
    logic [3:0]           w_einc;

    always_comb begin
        w_lim64 = 64'(r_limit);
        if (w_lim64 > MASK_C) w_lim64 = MASK_C;
        if (w_lim64 > DCAP_C) w_lim64 = DCAP_C;
    end
    assign w_lim  = w_lim64[VB-1:0];
    assign w_vidx = 64'(r_v) >> 1;
    assign w_pidx = 64'(r_p) >> 1;
    assign w_midx = 64'(r_m) >> 1;
    assign w_qext = (VB + 16)'(i_query_value);
    assign w_pext = (VB + 16)'(r_p);
    assign w_rsh  = {r_rem[VB-1:0], r_q[VB-1]};
    assign w_rsub = w_rsh - {1'b0, r_p};
    assign w_entry = r_rd_inr ? VB'(r_rd_data) : '0;
    assign w_einc = (r_e == 4'd15) ? 4'd15 : r_e + 4'd1;

    always_comb begin
        if (!r_v[0]) begin
            w_psel = VB'(2);
        end else if (w_entry < VB'(2)) begin
            w_psel = r_v;
        end else begin
            w_psel = w_entry;
        end
    end

    assign o_sts.clr_done = (r_idx == LAST_IDX);
    assign o_sts.m_gt_lim = (64'(r_m) > 64'(w_lim));
    assign o_sts.entry_nz = r_rd_inr && (r_rd_data != '0);
    assign o_sts.built    = r_built;
    assign o_sts.v_lt2    = (r_v < VB'(2));
    assign o_sts.v_gt_lim = (r_v > w_lim);
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.again    = (r_rem == '0) && (r_q > VB'(1));
    assign o_sts.out_free = !o_rsp_valid || i_rsp_ready;
    assign o_sts.fac_last = (r_v <= VB'(1)) || (r_n == LAST_ITEM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_idx] <= '0;
        end else if (i_cmd.wr_m && r_rd_inr && (r_rd_data == '0)) begin
            r_mem[w_midx[IW-1:0]] <= r_p[C_ENTRY_W-1:0];
        end
        if (i_cmd.rd_p) begin
            r_rd_data <= r_mem[w_pidx[IW-1:0]];
            r_rd_inr  <= (w_pidx < DEPTH_C);
        end else if (i_cmd.rd_m) begin
            r_rd_data <= r_mem[w_midx[IW-1:0]];
            r_rd_inr  <= (w_midx < DEPTH_C);
        end else if (i_cmd.rd_v) begin
            r_rd_data <= r_mem[w_vidx[IW-1:0]];
            r_rd_inr  <= (w_vidx < DEPTH_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= 16'hFFFF;
            r_built     <= 1'b0;
            o_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
                r_built <= 1'b0;
            end else if (i_cmd.set_built) begin
                r_built <= 1'b1;
            end
            if (i_cmd.emit_fac || i_cmd.emit_sts) begin
                o_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                o_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_v   <= w_qext[VB-1:0];
            r_idx <= '0;
            r_n   <= '0;
        end
        if (i_cmd.clr_step) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.sp_init) begin
            r_p <= VB'(3);
        end
        if (i_cmd.p_next) begin
            r_p <= r_p + VB'(2);
        end
        if (i_cmd.sp_sq) begin
            r_m <= r_p * r_p;
        end
        if (i_cmd.wr_m) begin
            r_m <= r_m + (MW'(r_p) << 1);
        end
        if (i_cmd.f_sel) begin
            r_p     <= w_psel;
            r_q     <= r_v;
            r_rem   <= '0;
            r_cnt   <= CW'(VB - 1);
            r_e     <= 4'd0;
            r_first <= 1'b1;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CW'(1);
            if (!w_rsub[VB]) begin
                r_rem <= w_rsub;
                r_q   <= {r_q[VB-2:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_q   <= {r_q[VB-2:0], 1'b0};
            end
        end
        if (i_cmd.f_chk) begin
            r_first <= 1'b0;
            if (r_rem == '0) begin
                r_v   <= r_q;
                r_e   <= w_einc;
                r_rem <= '0;
                r_cnt <= CW'(VB - 1);
            end else if (r_first) begin
                r_p <= r_v;
                r_v <= VB'(1);
                r_e <= 4'd1;
            end
        end
        if (i_cmd.emit_fac) begin
            r_n            <= r_n + 3'd1;
            o_rsp_prime    <= w_pext[15:0];
            o_rsp_exponent <= r_e;
            o_rsp_last     <= o_sts.fac_last;
            o_rsp_status   <= ST_FACTOR;
        end else if (i_cmd.emit_sts) begin
            o_rsp_prime    <= '0;
            o_rsp_exponent <= '0;
            o_rsp_last     <= 1'b1;
            o_rsp_status   <= i_cmd.sts_code;
        end
    end

endmodule

// ===== dv/spf_sieve_factorizer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spf_sieve_factorizer_checker
// Watches the request, result and limit-write channels, keeps its own sieve
// table and built flag, predicts every result transaction and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    spf_req_if          i_req,
    spf_rsp_if          i_rsp,
    output int          o_fail_count,
    output int          o_pending
);
    import spf_pkg::*;

    typedef struct packed {
        logic [15:0] prime;
        logic [3:0]  exponent;
        logic        last;
        logic [2:0]  status;
    } t_factor_item;

    logic [7:0]   spf_model [0:C_TABLE_DEPTH-1];
    logic         model_built;
    logic [16:0]  model_limit;
    t_factor_item factor_queue [$];

    function automatic logic [7:0] spf_lookup(input int unsigned v);
        return ((v >> 1) < C_TABLE_DEPTH) ? spf_model[v >> 1] : 8'd0;
    endfunction

    function automatic void push_item(input logic [15:0] p, input logic [3:0] e,
                                      input logic lst, input logic [2:0] st);
        t_factor_item it;
        it.prime = p;
        it.exponent = e;
        it.last = lst;
        it.status = st;
        factor_queue.insert(factor_queue.size(), it);
    endfunction

    function automatic void sieve_build();
        int unsigned p;
        int unsigned m;
        for (int i = 0; i < C_TABLE_DEPTH; i++) begin
            spf_model[i] = 8'd0;
        end
        for (p = 3; p * p <= model_limit; p += 2) begin
            if (spf_lookup(p) != 0) continue;
            for (m = p * p; m <= model_limit; m += 2 * p) begin
                if ((m >> 1) < C_TABLE_DEPTH && spf_model[m >> 1] == 0) begin
                    spf_model[m >> 1] = p[7:0];
                end
            end
        end
        model_built = 1'b1;
    endfunction

    function automatic void predict_factors(input logic kind, input logic [15:0] qv);
        int unsigned v;
        int unsigned p;
        int unsigned e;
        int n;
        if (kind == REQ_BUILD) begin
            sieve_build();
            push_item(16'd0, 4'd0, 1'b1, ST_BUILT);
            return;
        end
        v = qv;
        if (!model_built) begin
            push_item(16'd0, 4'd0, 1'b1, ST_NOT_BUILT);
            return;
        end
        if (v < 2) begin
            push_item(16'd0, 4'd0, 1'b1, ST_BELOW_TWO);
            return;
        end
        if (v > model_limit) begin
            push_item(16'd0, 4'd0, 1'b1, ST_ABOVE);
            return;
        end
        n = 0;
        while (v > 1 && n < C_MAX_ITEMS) begin
            if (v[0] == 1'b0) begin
                p = 2;
            end else begin
                p = spf_lookup(v);
                if (p < 2 || v % p != 0) p = v;
            end
            e = 0;
            do begin
                v = v / p;
                e++;
            end while (v > 1 && v % p == 0);
            if (e > 15) e = 15;
            n++;
            push_item(p[15:0], e[3:0], (v <= 1 || n == C_MAX_ITEMS), ST_FACTOR);
        end
    endfunction

    always @(posedge i_clk) begin
        t_factor_item want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            model_built = 1'b0;
            model_limit = 17'd65535;
            o_fail_count <= 0;
            factor_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                model_limit = {1'b0, i_cfg_data};
                if (model_limit > 17'(2 * C_TABLE_DEPTH - 1)) begin
                    model_limit = 17'(2 * C_TABLE_DEPTH - 1);
                end
                model_built = 1'b0;
            end
            if (i_req.valid && i_req.ready) begin
                predict_factors(i_req.req_type, i_req.query_value);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (factor_queue.size() == 0) begin
                    $error("unexpected result transaction prime=%0d status=%0d",
                           i_rsp.prime, i_rsp.status);
                    errs = errs + 1;
                end else begin
                    want = factor_queue.pop_front();
                    if (want.prime !== i_rsp.prime) begin
                        $error("prime: expected %0d, got %0d", want.prime, i_rsp.prime);
                        errs = errs + 1;
                    end
                    if (want.exponent !== i_rsp.exponent) begin
                        $error("exponent: expected %0d, got %0d", want.exponent,
                               i_rsp.exponent);
                        errs = errs + 1;
                    end
                    if (want.last !== i_rsp.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_rsp.last);
                        errs = errs + 1;
                    end
                    if (want.status !== i_rsp.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
        o_pending <= factor_queue.size();
    end
endmodule

// ===== dv/spf_sieve_factorizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spf_sieve_factorizer_test
// Drives builds, limit writes and factorization queries with random gaps and
// result stalls, including a long result hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer_test;
    import spf_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          hold_off;

    spf_req_if req_ch ();
    spf_rsp_if rsp_ch ();

    spf_sieve_factorizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    spf_sieve_factorizer_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("spf_sieve_factorizer test failed");
            $finish;
        end
    end

    initial begin
        int gap;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
            end else if (rsp_ch.ready && !rsp_ch.valid) begin
                rsp_ch.ready <= 1'b1;
            end else if (rsp_ch.ready && rsp_ch.valid) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic kind, input logic [15:0] qv, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 19) : 0;
        repeat (gap) @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.req_type = kind;
        req_ch.query_value = qv;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] lim);
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_queries(input int count, input logic [15:0] lim);
        logic [15:0] qv;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) qv = 16'($urandom_range(0, 1));
            else if (pick == 1) qv = 16'($urandom);
            else if (pick == 2) qv = 16'(32'(lim) - $urandom_range(0, 2));
            else qv = 16'($urandom_range(2, lim));
            send_request(REQ_QUERY, qv, ($urandom_range(0, 4) != 0) || i < 10);
        end
    endtask

    initial begin
        logic [15:0] limits [6];
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_QUERY;
        req_ch.query_value = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(REQ_QUERY, 16'd100, 1'b0);
        send_request(REQ_BUILD, 16'hFFFF, 1'b0);
        send_request(REQ_QUERY, 16'd0, 1'b0);
        send_request(REQ_QUERY, 16'd1, 1'b0);
        send_request(REQ_QUERY, 16'd2, 1'b0);
        send_request(REQ_QUERY, 16'd32768, 1'b0);
        send_request(REQ_QUERY, 16'd65535, 1'b0);
        send_request(REQ_QUERY, 16'd65521, 1'b0);
        send_request(REQ_QUERY, 16'd30030, 1'b0);
        send_request(REQ_QUERY, 16'd65025, 1'b0);
        send_request(REQ_QUERY, 16'd59049, 1'b0);
        send_request(REQ_QUERY, 16'd255, 1'b1);
        send_request(REQ_QUERY, 16'd51758, 1'b1);
        drain_results();

        write_limit(16'd1000);
        send_request(REQ_QUERY, 16'd7, 1'b0);
        send_request(REQ_BUILD, 16'h0000, 1'b0);
        send_request(REQ_QUERY, 16'd1001, 1'b0);
        send_request(REQ_QUERY, 16'd1000, 1'b0);
        send_request(REQ_QUERY, 16'd997, 1'b0);
        drain_results();

        limits[0] = 16'd3;
        limits[1] = 16'd2;
        limits[2] = 16'd200;
        limits[3] = 16'd5000;
        limits[4] = 16'd65535;
        limits[5] = 16'd12345;
        foreach (limits[k]) begin
            write_limit(limits[k]);
            send_request(REQ_BUILD, 16'($urandom), 1'b1);
            if (k == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                    random_queries(20, limits[k]);
                join
            end
            random_queries(k == 4 ? 130 : 30, limits[k]);
            if ($urandom_range(0, 1)) send_request(REQ_BUILD, 16'($urandom), 1'b1);
            drain_results();
        end

        drain_results();
        if (fail_count == 0) begin
            $display("spf_sieve_factorizer test passed");
        end else begin
            $display("spf_sieve_factorizer test failed");
        end
        $finish;
    end
endmodule
